// ===== hw/rtl/raa_pkg.sv =====
// ----------------------------------------------------------------------------
// raa_pkg
// Shared types and constants for the rectangle atlas allocator.
// ----------------------------------------------------------------------------
package raa_pkg;
  localparam int MaxFree   = 64;
  localparam int CoordBits = 15;
  localparam int IdxBits   = $clog2(MaxFree);
  localparam int CntBits   = $clog2(MaxFree + 1);
  localparam int ReqBits   = 12;
  localparam logic [ReqBits-1:0] ReqMax = '1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } frect_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCAN,
    ST_BRD,
    ST_APP1,
    ST_APP2,
    ST_CRD,
    ST_CUT,
    ST_DRD,
    ST_DEL,
    ST_DONE
  } state_t;
endpackage

// ===== hw/rtl/rectangle_atlas_allocator_core.sv =====
// ----------------------------------------------------------------------------
// rectangle_atlas_allocator_core
// Guillotine free-list atlas packer with best area fit, one shared compare
// unit stepping over the free list under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+----------------------
//  command  | start, op, rect_width, rect_height, busy | start && !busy
//  result   | done, placed, pos_x, pos_y, ...          | done (one cycle)
//  config   | cfg_we, cfg_index, cfg_wdata             | cfg_we
//
// A start keeps busy high only for the result cycle.
// A place with N free rectangles at the search and M after the leftovers are
// appended (M <= N + 2, M <= 64) runs a search pass, a cut pass and a
// removal pass over the list memory, one entry per cycle, each pass opened
// by its read state (SRD, CRD, DRD), and then ends with the result cycle.
// A place that finds no fit ends after the search pass.
// A new command is taken as soon as busy is low.
// rst is synchronous and active high; the list memory is not cleared.
// Results cannot be stalled; busy holds off commands.
module rectangle_atlas_allocator_core
  import raa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  logic [CoordBits-1:0] rect_width,
  input  logic [CoordBits-1:0] rect_height,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CoordBits-1:0] cfg_wdata,
  output logic                 done,
  output logic                 placed,
  output logic [CoordBits-1:0] pos_x,
  output logic [CoordBits-1:0] pos_y,
  output logic [ReqBits-1:0]   request_index,
  output logic                 all_fit_so_far,
  output logic                 list_overflow
);

  // list memory, write-first on a same-address read
  frect_t mem [MaxFree];
  frect_t rd;
  logic [IdxBits-1:0] raddr;
  logic               we;
  logic [IdxBits-1:0] waddr;
  frect_t             wdata;
  logic [MaxFree-1:0] mark;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

  state_t state, state_next;
  coord_t atlas_w, atlas_h, rw, rh;
  logic [CntBits-1:0] cnt, idx;
  logic [IdxBits-1:0] best;
  logic [2*CoordBits-1:0] best_area;
  logic   found, ovf;
  frect_t b;
  logic [ReqBits-1:0] req;
  logic   fit;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w <= CoordBits'(1024);
      atlas_h <= CoordBits'(1024);
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) atlas_w <= cfg_wdata;
      else atlas_h <= cfg_wdata;
    end
  end

  // shared compare unit on the entry just read
  logic [IdxBits-1:0] ci;
  logic [2*CoordBits-1:0] area;
  logic fits, ovl, cut_w, kill;
  logic signed [CoordBits+1:0] dx, dy;
  logic [CoordBits:0] fxe, fye, pxe, pye;
  assign ci    = idx[IdxBits-1:0] - IdxBits'(1);
  assign area  = rd.w * rd.h;
  assign fits  = (rd.w >= rw) && (rd.h >= rh);
  assign fxe   = {1'b0, rd.x} + {1'b0, rd.w};
  assign fye   = {1'b0, rd.y} + {1'b0, rd.h};
  assign pxe   = {1'b0, b.x} + {1'b0, rw};
  assign pye   = {1'b0, b.y} + {1'b0, rh};
  assign ovl   = ({1'b0, rd.x} < pxe) && ({1'b0, b.x} < fxe) &&
                 ({1'b0, rd.y} < pye) && ({1'b0, b.y} < fye);
  assign dx    = $signed({2'b0, b.x}) - $signed({2'b0, rd.x});
  assign dy    = $signed({2'b0, b.y}) - $signed({2'b0, rd.y});
  assign cut_w = dx > dy;
  assign kill  = cut_w ? (dx <= 0) : (dy <= 0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = (op == OP_START) ? ST_DONE : ST_SRD;
      ST_SRD:  state_next = (cnt == '0) ? ST_DONE : ST_SCAN;
      ST_SCAN: if (idx == cnt) state_next = (found || fits) ? ST_BRD : ST_DONE;
      ST_BRD:  state_next = ST_APP1;
      ST_APP1: state_next = ST_APP2;
      ST_APP2: state_next = ST_CRD;
      ST_CRD:  state_next = ST_CUT;
      ST_CUT:  if (idx == cnt) state_next = ST_DRD;
      ST_DRD:  state_next = ST_DEL;
      ST_DEL:  if (idx == '0) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory address and write control
  // rd holds the chosen entry during APP1, b holds it from APP2 on
  frect_t a1, a2;
  logic [CntBits-1:0] last;
  assign a1 = '{x: rd.x, y: CoordBits'(rd.y + rh), w: rd.w, h: CoordBits'(rd.h - rh)};
  assign a2 = '{x: CoordBits'(b.x + rw), y: b.y, w: CoordBits'(b.w - rw), h: b.h};
  assign last = cnt - CntBits'(1);
  logic del_hit;
  assign del_hit = (state == ST_DEL) && (idx != '0) && mark[ci];

  always_comb begin
    raddr = idx[IdxBits-1:0];
    we    = 1'b0;
    waddr = ci;
    wdata = rd;
    case (state)
      ST_IDLE: begin
        we    = start && (op == OP_START);
        waddr = '0;
        wdata = '{x: '0, y: '0, w: atlas_w, h: atlas_h};
      end
      ST_BRD: raddr = best;
      ST_APP1: begin
        we    = (a1.w != '0) && (a1.h != '0) && (cnt < CntBits'(MaxFree));
        waddr = cnt[IdxBits-1:0];
        wdata = a1;
      end
      ST_APP2: begin
        we    = (a2.w != '0) && (a2.h != '0) && (cnt < CntBits'(MaxFree));
        waddr = cnt[IdxBits-1:0];
        wdata = a2;
      end
      ST_CUT: begin
        we = (idx != '0) && (ci != best) && ovl && !kill;
        wdata = rd;
        if (cut_w) wdata.w = CoordBits'(dx);
        else wdata.h = CoordBits'(dy);
      end
      ST_DRD, ST_DEL: begin
        raddr = del_hit ? last[IdxBits-1:0] - IdxBits'(1) : last[IdxBits-1:0];
        // rd holds mem[cnt-1] here; it moves into the removed slot
        we    = del_hit && (ci != last[IdxBits-1:0]);
        wdata = rd;
      end
      default: ;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      req   <= '0;
      fit   <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state_next == ST_DONE) && (state != ST_DONE);
      case (state)
        ST_IDLE: if (start) begin
          rw <= rect_width; rh <= rect_height;
          idx <= '0; found <= 1'b0; ovf <= 1'b0; placed <= 1'b0;
          pos_x <= '0; pos_y <= '0; mark <= '0;
          if (op == OP_START) begin
            cnt <= CntBits'(1); req <= '0; fit <= 1'b1;
          end else if (req != ReqMax) begin
            req <= req + ReqBits'(1);
          end
        end
        ST_SRD: begin
          idx <= CntBits'(1);
          if (cnt == '0) fit <= 1'b0;
        end
        ST_SCAN: begin
          if (fits && (!found || area < best_area)) begin
            found <= 1'b1; best <= ci; best_area <= area;
          end
          if (idx != cnt) idx <= idx + CntBits'(1);
          else if (!(found || fits)) fit <= 1'b0;
        end
        ST_BRD: ;
        ST_APP1: begin
          b <= rd; placed <= 1'b1; pos_x <= rd.x; pos_y <= rd.y;
          mark[best] <= 1'b1;
        end
        ST_APP2, ST_CRD: ;
        default: ;
      endcase
      if (state == ST_APP1 || state == ST_APP2) begin
        if ((state == ST_APP1 ? (a1.w != '0 && a1.h != '0) :
                                (a2.w != '0 && a2.h != '0))) begin
          if (cnt < CntBits'(MaxFree)) cnt <= cnt + CntBits'(1);
          else ovf <= 1'b1;
        end
      end
      if (state == ST_APP2) idx <= '0;
      if (state == ST_CRD) idx <= CntBits'(1);
      if (state == ST_CUT) begin
        if (idx != '0 && ci != best && ovl && kill) mark[ci] <= 1'b1;
        if (idx != cnt) idx <= idx + CntBits'(1);
      end
      if (state == ST_DEL) begin
        if (idx != '0) idx <= idx - CntBits'(1);
        if (del_hit) cnt <= cnt - CntBits'(1);
      end
    end
  end

  assign busy           = (state != ST_IDLE);
  assign request_index  = req;
  assign all_fit_so_far = fit;
  assign list_overflow  = ovf;

  // assertions
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntBits'(MaxFree)) else $error("free count above capacity");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command not taken");
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result without command");
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    done && !placed |-> pos_x == '0 && pos_y == '0)
    else $error("position on a miss");
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangle atlas allocator: random command
// traffic with bursty idle gaps, a built-in free-list packer that predicts
// every result, and a field-by-field compare on each result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import raa_pkg::*;

  typedef struct {
    logic   op;
    coord_t rw;
    coord_t rh;
  } cmd_t;

  typedef struct {
    logic         placed;
    coord_t       px;
    coord_t       py;
    logic [11:0]  req;
    logic         fit;
    logic         ovf;
  } placement_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 op;
  logic [CoordBits-1:0] rect_width;
  logic [CoordBits-1:0] rect_height;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CoordBits-1:0] cfg_wdata;
  logic                 done;
  logic                 placed;
  logic [CoordBits-1:0] pos_x;
  logic [CoordBits-1:0] pos_y;
  logic [ReqBits-1:0]   request_index;
  logic                 all_fit_so_far;
  logic                 list_overflow;

  rectangle_atlas_allocator_core i_dut (.*);

  // packer state
  frect_t      pk_list[MaxFree];
  int unsigned pk_count;
  int unsigned pk_req;
  logic        pk_fit;
  coord_t      pk_aw;
  coord_t      pk_ah;

  cmd_t       cmd_queue[$];
  placement_t placement_queue[$];
  int         mismatches;
  int         stall_cycles;
  int         transfers;
  bit         quiet_tail;
  bit         timed_out;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit rect_overlap(frect_t a, frect_t b);
    int unsigned ax, ay, bx, by;
    ax = a.x; ay = a.y; bx = b.x; by = b.y;
    return ax < bx + b.w && bx < ax + a.w && ay < by + b.h && by < ay + a.h;
  endfunction

  function automatic bit pack_append(int unsigned x, int unsigned y,
                                     int unsigned w, int unsigned h);
    if (w == 0 || h == 0) return 1'b1;
    if (pk_count >= MaxFree) return 1'b0;
    pk_list[pk_count] = '{x: coord_t'(x), y: coord_t'(y), w: coord_t'(w), h: coord_t'(h)};
    pk_count++;
    return 1'b1;
  endfunction

  // predict the result of one command and update the packer
  function automatic placement_t pack_command(cmd_t c);
    placement_t  r;
    int unsigned best, best_area, area, cnt;
    bit          found;
    frect_t      b, p;
    bit          mark[MaxFree];
    int          dx, dy;
    r = '{placed: 1'b0, px: '0, py: '0, req: '0, fit: 1'b1, ovf: 1'b0};
    if (c.op == OP_START) begin
      pk_list[0] = '{x: '0, y: '0, w: pk_aw, h: pk_ah};
      pk_count = 1;
      pk_req = 0;
      pk_fit = 1'b1;
    end else begin
      if (pk_req < 4095) pk_req++;
      found = 1'b0;
      best = 0;
      best_area = 0;
      for (int j = 0; j < pk_count; j++) begin
        area = pk_list[j].w * pk_list[j].h;
        if (pk_list[j].w >= c.rw && pk_list[j].h >= c.rh && (!found || area < best_area)) begin
          found = 1'b1;
          best = j;
          best_area = area;
        end
      end
      if (!found) begin
        pk_fit = 1'b0;
      end else begin
        b = pk_list[best];
        p = '{x: b.x, y: b.y, w: c.rw, h: c.rh};
        r.placed = 1'b1;
        r.px = b.x;
        r.py = b.y;
        if (!pack_append(b.x, b.y + c.rh, b.w, b.h - c.rh)) r.ovf = 1'b1;
        if (!pack_append(b.x + c.rw, b.y, b.w - c.rw, b.h)) r.ovf = 1'b1;
        foreach (mark[j]) mark[j] = 1'b0;
        mark[best] = 1'b1;
        for (int j = 0; j < pk_count; j++) begin
          if (j == best || !rect_overlap(pk_list[j], p)) continue;
          dx = int'(p.x) - int'(pk_list[j].x);
          dy = int'(p.y) - int'(pk_list[j].y);
          if (dx > dy) begin
            if (dx <= 0) mark[j] = 1'b1;
            else pk_list[j].w = coord_t'(dx);
          end else begin
            if (dy <= 0) mark[j] = 1'b1;
            else pk_list[j].h = coord_t'(dy);
          end
        end
        cnt = pk_count;
        for (int j = cnt - 1; j >= 0; j--) begin
          if (mark[j]) begin
            pk_list[j] = pk_list[pk_count - 1];
            pk_count--;
          end
        end
      end
    end
    r.req = pk_req[11:0];
    r.fit = pk_fit;
    return r;
  endfunction

  // command driver, falling edge, bursty gaps
  // start is raised only while the block is idle, so it transfers at the next edge
  int gap;
  initial gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      start       <= 1'b0;
      op          <= OP_START;
      rect_width  <= '0;
      rect_height <= '0;
    end else if (busy) begin
      start <= 1'b0;
    end else begin
      if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (gap > 0) begin
        gap = gap - 1;
        start <= 1'b0;
      end else begin
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(1, 9);
          start <= 1'b0;
        end else begin
          start       <= 1'b1;
          op          <= cmd_queue[0].op;
          rect_width  <= cmd_queue[0].rw;
          rect_height <= cmd_queue[0].rh;
        end
      end
    end
  end

  // command transfer feeds the packer; result monitor checks it
  always @(posedge clk) begin
    placement_t exp_r;
    if (!rst) begin
      if (start && !busy) begin
        void'(cmd_queue.pop_front());
        placement_queue.push_back(pack_command('{op: op, rw: rect_width, rh: rect_height}));
        transfers++;
      end
      if (done) begin
        if (placement_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result strobe");
        end else begin
          exp_r = placement_queue.pop_front();
          if (exp_r.placed !== placed || exp_r.px !== pos_x || exp_r.py !== pos_y ||
              exp_r.req !== request_index || exp_r.fit !== all_fit_so_far ||
              exp_r.ovf !== list_overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp p%0d x%0d y%0d i%0d f%0d o%0d got p%0d x%0d y%0d i%0d f%0d o%0d",
                       exp_r.placed, exp_r.px, exp_r.py, exp_r.req, exp_r.fit, exp_r.ovf,
                       placed, pos_x, pos_y, request_index, all_fit_so_far, list_overflow);
          end
        end
      end
    end
  end

  // watchdog on cycles without a transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || start || placement_queue.size() != 0) begin
      @(posedge clk);
      if (stall_cycles > 5000) begin
        timed_out = 1'b1;
        return;
      end
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, coord_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_WIDTH) pk_aw = val;
    else pk_ah = val;
  endtask

  function automatic coord_t rand_size(int unsigned span);
    case ($urandom_range(0, 9))
      0:       return coord_t'($urandom_range(0, 32767));
      1:       return '0;
      default: return coord_t'($urandom_range(1, span));
    endcase
  endfunction

  task automatic queue_session(int unsigned n, int unsigned span);
    cmd_queue.push_back('{op: OP_START, rw: coord_t'($urandom), rh: coord_t'($urandom)});
    for (int i = 0; i < n; i++)
      cmd_queue.push_back('{op: OP_PLACE, rw: rand_size(span), rh: rand_size(span)});
  endtask

  // stimulus
  initial begin
    coord_t aw[5], ah[5];
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = CFG_WIDTH; cfg_wdata = '0;
    mismatches = 0; stall_cycles = 0; transfers = 0; quiet_tail = 1'b0; timed_out = 1'b0;
    pk_count = 0; pk_req = 0; pk_fit = 1'b1; pk_aw = 15'd1024; pk_ah = 15'd1024;
    foreach (pk_list[j]) pk_list[j] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: place before start, extremes, zero sizes, exact fit
    cmd_queue.push_back('{op: OP_PLACE, rw: 15'd1, rh: 15'd1});
    cmd_queue.push_back('{op: OP_START, rw: '1, rh: '1});
    cmd_queue.push_back('{op: OP_PLACE, rw: '0, rh: '0});
    cmd_queue.push_back('{op: OP_PLACE, rw: '1, rh: '1});
    cmd_queue.push_back('{op: OP_PLACE, rw: 15'd1024, rh: 15'd1});
    cmd_queue.push_back('{op: OP_PLACE, rw: 15'd100, rh: 15'd200});
    cmd_queue.push_back('{op: OP_PLACE, rw: 15'd300, rh: 15'd50});
    cmd_queue.push_back('{op: OP_PLACE, rw: 15'd924, rh: 15'd823});
    cmd_queue.push_back('{op: OP_PLACE, rw: 15'd16384, rh: 15'd0});
    cmd_queue.push_back('{op: OP_PLACE, rw: 15'd0, rh: 15'd16384});
    wait_drained();

    // settings including the extremes and an empty atlas
    aw = '{15'd0, 15'd16384, 15'd1, 15'd64, 15'd200};
    ah = '{15'd5, 15'd16384, 15'd1, 15'd48, 15'd31};
    for (int s = 0; s < 5 && !timed_out; s++) begin
      write_reg(CFG_WIDTH, aw[s]);
      write_reg(CFG_HEIGHT, ah[s]);
      if (s == 0) begin
        cmd_queue.push_back('{op: OP_START, rw: '0, rh: '0});
        cmd_queue.push_back('{op: OP_PLACE, rw: '0, rh: '0});
        cmd_queue.push_back('{op: OP_PLACE, rw: 15'd1, rh: 15'd0});
      end
      for (int k = 0; k < 5; k++)
        queue_session($urandom_range(8, 40), (aw[s] > 4) ? aw[s] / 3 : 2);
      // many tiny placements to fill the list and hit overflow
      if (s == 3) queue_session(160, 3);
      if (s == 4) quiet_tail = 1'b1;
      wait_drained();
    end

    if (timed_out) begin
      $display("SCOREBOARD MISMATCH");
    end else if (mismatches == 0 && placement_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
